@@ hw/rtl/qrs_pkg.sv @@
package qrs_pkg;

    // field widths
    localparam int COEF_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int ROOT_W    = 40;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int DISC_W    = 2 * COEF_W + 2;
    // -b scaled by 2^FRAC_W
    localparam int NB_W      = COEF_W + 1 + FRAC_W;
    // square root: one result bit per step
    localparam int SQ_STEPS  = DISC_W / 2 + FRAC_W;
    localparam int SQ_ROOT_W = SQ_STEPS;
    localparam int REM_W     = SQ_ROOT_W + 2;
    // numerator -b*2^F +/- s, signed, and its magnitude
    localparam int NUM_W     = SQ_ROOT_W + 2;
    localparam int NMAG_W    = NUM_W - 1;
    // |2a|
    localparam int DEN_W     = COEF_W + 1;
    localparam int DIV_STEPS = NMAG_W;

    typedef enum logic [1:0] {
        CLS_TWO_REAL   = 2'd0,
        CLS_ONE_REAL   = 2'd1,
        CLS_COMPLEX    = 2'd2,
        CLS_DEGENERATE = 2'd3
    } root_class_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [SQ_ROOT_W-1:0] root;
    } sq_state_t;

    typedef struct packed {
        root_class_t       cls;
        logic [DISC_W-1:0] disc;
        logic [NB_W-1:0]   nb;
        logic              a_neg;
        logic [DEN_W-1:0]  den_mag;
    } sq_side_t;

    typedef struct packed {
        logic [DEN_W-1:0]  rem;
        logic [NMAG_W-1:0] nq;
    } div_state_t;

    typedef struct packed {
        root_class_t       cls;
        logic [DISC_W-1:0] disc;
        logic              p_neg;
        logic              m_neg;
        logic [DEN_W-1:0]  den_mag;
    } div_side_t;

    // one digit of the restoring square root
    function automatic sq_state_t sqrt_step(sq_state_t st, logic [1:0] pair);
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        sq_state_t        res;
        cur   = {st.rem[REM_W-3:0], pair};
        trial = {st.root, 2'b01};
        if (cur >= trial) begin
            res.rem  = cur - trial;
            res.root = {st.root[SQ_ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = cur;
            res.root = {st.root[SQ_ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // one quotient bit of the restoring divider
    function automatic div_state_t div_step(div_state_t st, logic [DEN_W-1:0] den);
        logic [DEN_W-1:0] cur;
        div_state_t       res;
        cur = {st.rem[DEN_W-2:0], st.nq[NMAG_W-1]};
        if (cur >= den) begin
            res.rem = cur - den;
            res.nq  = {st.nq[NMAG_W-2:0], 1'b1};
        end else begin
            res.rem = cur;
            res.nq  = {st.nq[NMAG_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/quadratic_root_solver.sv @@
// Quadratic root solver.
// Input channel s_valid/s_ready carries signed coefficients a, b, c.
// Output channel m_valid/m_ready carries the root class, both roots in
// signed fixed point with 16 fraction bits, and the discriminant b*b-4ac.
// Classes: two real, one real (both roots equal), complex pair (roots
// zero) and degenerate when a is zero (roots zero, discriminant b*b).
// Throughput: one transaction per cycle while the receiver takes results.
// The pipeline is a bit-per-stage square root (33 stages) followed by two
// bit-per-stage dividers in parallel (34 stages).
// Every stage has a valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up and s_ready stays high while
// any stage of the pipeline is empty, even when the receiver stalls.
// When m_ready is low the result holds on the output until taken and the
// pipeline behind it fills up; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; data in flight
// is discarded. No configuration and no state between transactions.
module quadratic_root_solver (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [qrs_pkg::COEF_W-1:0]    s_coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]    s_coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]    s_coef_c,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic        [1:0]                    m_root_class,
    output logic signed [qrs_pkg::ROOT_W-1:0]    m_root_plus,
    output logic signed [qrs_pkg::ROOT_W-1:0]    m_root_minus,
    output logic signed [qrs_pkg::DISC_W-1:0]    m_discriminant
);

    localparam int SQ0   = 1;
    localparam int COMB  = SQ0 + qrs_pkg::SQ_STEPS + 1;
    localparam int N_ST  = COMB + qrs_pkg::DIV_STEPS + 2;
    localparam int OUT_I = N_ST - 1;

    logic [N_ST-1:0] pv_reg;
    logic [N_ST-1:0] pv_next;
    logic [N_ST-1:0] adv;

    // per-stage advance, from the output back to the input
    always_comb begin
        adv[OUT_I] = !pv_reg[OUT_I] || m_ready;
        for (int i = OUT_I - 1; i >= 0; i--) begin
            adv[i] = !pv_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        pv_next[0] = adv[0] ? s_valid : pv_reg[0];
        for (int i = 1; i < N_ST; i++) begin
            pv_next[i] = adv[i] ? pv_reg[i-1] : pv_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else begin
            pv_reg <= pv_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = pv_reg[OUT_I];

    // stage 0: products
    logic signed [qrs_pkg::COEF_W-1:0] a_reg;
    logic signed [qrs_pkg::COEF_W-1:0] b_reg;
    logic signed [qrs_pkg::PROD_W-1:0] bb_reg;
    logic signed [qrs_pkg::PROD_W-1:0] ac_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a_reg  <= s_coef_a;
            b_reg  <= s_coef_b;
            bb_reg <= s_coef_b * s_coef_b;
            ac_reg <= s_coef_a * s_coef_c;
        end
    end

    // stage 1: discriminant, class, scaled -b and |2a|
    logic signed [qrs_pkg::DISC_W-1:0] disc_c;
    logic signed [qrs_pkg::NB_W-1:0]   nb_c;
    logic        [qrs_pkg::COEF_W-1:0] a_mag_c;
    qrs_pkg::root_class_t              cls_c;
    logic        [qrs_pkg::DISC_W-1:0] d_c;

    always_comb begin
        disc_c  = qrs_pkg::DISC_W'(bb_reg) - (qrs_pkg::DISC_W'(ac_reg) <<< 2);
        nb_c    = -(qrs_pkg::NB_W'(b_reg) <<< qrs_pkg::FRAC_W);
        a_mag_c = a_reg[qrs_pkg::COEF_W-1] ? qrs_pkg::COEF_W'(-a_reg)
                                           : qrs_pkg::COEF_W'(a_reg);
        if (a_reg == '0) begin
            cls_c = qrs_pkg::CLS_DEGENERATE;
        end else if (disc_c[qrs_pkg::DISC_W-1]) begin
            cls_c = qrs_pkg::CLS_COMPLEX;
        end else if (disc_c == '0) begin
            cls_c = qrs_pkg::CLS_ONE_REAL;
        end else begin
            cls_c = qrs_pkg::CLS_TWO_REAL;
        end
        d_c = (cls_c == qrs_pkg::CLS_TWO_REAL) ? disc_c : '0;
    end

    qrs_pkg::sq_state_t               sq_reg      [0:qrs_pkg::SQ_STEPS];
    logic [qrs_pkg::DISC_W-1:0]       sq_d_reg    [0:qrs_pkg::SQ_STEPS];
    qrs_pkg::sq_side_t                sq_side_reg [0:qrs_pkg::SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (adv[SQ0]) begin
            sq_reg[0]              <= '0;
            sq_d_reg[0]            <= d_c;
            sq_side_reg[0].cls     <= cls_c;
            sq_side_reg[0].disc    <= disc_c;
            sq_side_reg[0].nb      <= nb_c;
            sq_side_reg[0].a_neg   <= a_reg[qrs_pkg::COEF_W-1];
            sq_side_reg[0].den_mag <= {a_mag_c, 1'b0};
        end
    end

    // square root stages, one result bit each
    for (genvar k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_sqrt
        always_ff @(posedge aclk) begin
            if (adv[SQ0+1+k]) begin
                sq_reg[k+1]      <= qrs_pkg::sqrt_step(sq_reg[k],
                                        sq_d_reg[k][qrs_pkg::DISC_W-1 -: 2]);
                sq_d_reg[k+1]    <= sq_d_reg[k] << 2;
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // combine: numerators -b*2^F +/- s, split into sign and magnitude
    qrs_pkg::sq_side_t                sq_last;
    logic signed [qrs_pkg::NUM_W-1:0] num_p_c;
    logic signed [qrs_pkg::NUM_W-1:0] num_m_c;
    logic signed [qrs_pkg::NUM_W-1:0] nb_ext_c;
    logic signed [qrs_pkg::NUM_W-1:0] s_ext_c;

    always_comb begin
        sq_last  = sq_side_reg[qrs_pkg::SQ_STEPS];
        nb_ext_c = qrs_pkg::NUM_W'($signed(sq_last.nb));
        s_ext_c  = $signed({2'b00, sq_reg[qrs_pkg::SQ_STEPS].root});
        num_p_c  = nb_ext_c + s_ext_c;
        num_m_c  = nb_ext_c - s_ext_c;
    end

    qrs_pkg::div_state_t dp_reg      [0:qrs_pkg::DIV_STEPS];
    qrs_pkg::div_state_t dm_reg      [0:qrs_pkg::DIV_STEPS];
    qrs_pkg::div_side_t  dv_side_reg [0:qrs_pkg::DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (adv[COMB]) begin
            dp_reg[0].rem <= '0;
            dp_reg[0].nq  <= num_p_c[qrs_pkg::NUM_W-1] ? qrs_pkg::NMAG_W'(-num_p_c)
                                                       : qrs_pkg::NMAG_W'(num_p_c);
            dm_reg[0].rem <= '0;
            dm_reg[0].nq  <= num_m_c[qrs_pkg::NUM_W-1] ? qrs_pkg::NMAG_W'(-num_m_c)
                                                       : qrs_pkg::NMAG_W'(num_m_c);
            dv_side_reg[0].cls     <= sq_last.cls;
            dv_side_reg[0].disc    <= sq_last.disc;
            dv_side_reg[0].p_neg   <= num_p_c[qrs_pkg::NUM_W-1] ^ sq_last.a_neg;
            dv_side_reg[0].m_neg   <= num_m_c[qrs_pkg::NUM_W-1] ^ sq_last.a_neg;
            dv_side_reg[0].den_mag <= sq_last.den_mag;
        end
    end

    // divider stages, one quotient bit each for both roots
    for (genvar k = 0; k < qrs_pkg::DIV_STEPS; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv[COMB+1+k]) begin
                dp_reg[k+1]      <= qrs_pkg::div_step(dp_reg[k], dv_side_reg[k].den_mag);
                dm_reg[k+1]      <= qrs_pkg::div_step(dm_reg[k], dv_side_reg[k].den_mag);
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // output stage: apply signs, zero roots that are not real
    qrs_pkg::div_side_t                dv_last;
    logic signed [qrs_pkg::ROOT_W-1:0] qp_c;
    logic signed [qrs_pkg::ROOT_W-1:0] qm_c;
    logic signed [qrs_pkg::ROOT_W-1:0] rp_c;
    logic signed [qrs_pkg::ROOT_W-1:0] rm_c;
    logic                              real_c;

    always_comb begin
        dv_last = dv_side_reg[qrs_pkg::DIV_STEPS];
        qp_c    = $signed(qrs_pkg::ROOT_W'(dp_reg[qrs_pkg::DIV_STEPS].nq));
        qm_c    = $signed(qrs_pkg::ROOT_W'(dm_reg[qrs_pkg::DIV_STEPS].nq));
        real_c  = (dv_last.cls == qrs_pkg::CLS_TWO_REAL) ||
                  (dv_last.cls == qrs_pkg::CLS_ONE_REAL);
        rp_c    = !real_c ? '0 : (dv_last.p_neg ? -qp_c : qp_c);
        rm_c    = !real_c ? '0 : (dv_last.m_neg ? -qm_c : qm_c);
    end

    qrs_pkg::root_class_t              cls_out_reg;
    logic signed [qrs_pkg::ROOT_W-1:0] rp_out_reg;
    logic signed [qrs_pkg::ROOT_W-1:0] rm_out_reg;
    logic signed [qrs_pkg::DISC_W-1:0] disc_out_reg;

    always_ff @(posedge aclk) begin
        if (adv[OUT_I]) begin
            cls_out_reg  <= dv_last.cls;
            rp_out_reg   <= rp_c;
            rm_out_reg   <= rm_c;
            disc_out_reg <= $signed(dv_last.disc);
        end
    end

    assign m_root_class   = cls_out_reg;
    assign m_root_plus    = rp_out_reg;
    assign m_root_minus   = rm_out_reg;
    assign m_discriminant = disc_out_reg;

    // an empty output stage always lets a new transaction in
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    a_one_real: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_root_class == qrs_pkg::CLS_ONE_REAL)
        |-> (m_discriminant == '0) && (m_root_plus == m_root_minus))
        else $error("single root class inconsistent");

    a_complex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_root_class == qrs_pkg::CLS_COMPLEX)
        |-> m_discriminant[qrs_pkg::DISC_W-1] && (m_root_plus == '0)
            && (m_root_minus == '0))
        else $error("complex class inconsistent");

    a_degenerate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_root_class == qrs_pkg::CLS_DEGENERATE)
        |-> !m_discriminant[qrs_pkg::DISC_W-1] && (m_root_plus == '0)
            && (m_root_minus == '0))
        else $error("degenerate class inconsistent");

endmodule

@@ bench/root_checker.sv @@
`timescale 1ns / 100ps

module root_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [qrs_pkg::COEF_W-1:0]    s_coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]    s_coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]    s_coef_c,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic        [1:0]                    m_root_class,
    input  logic signed [qrs_pkg::ROOT_W-1:0]    m_root_plus,
    input  logic signed [qrs_pkg::ROOT_W-1:0]    m_root_minus,
    input  logic signed [qrs_pkg::DISC_W-1:0]    m_discriminant,
    output int                                   fail_count,
    output int                                   pending_count,
    output int                                   class_seen [4]
);

    typedef struct packed {
        qrs_pkg::root_class_t              cls;
        logic signed [qrs_pkg::ROOT_W-1:0] plus;
        logic signed [qrs_pkg::ROOT_W-1:0] minus;
        logic signed [qrs_pkg::DISC_W-1:0] disc;
    } roots_t;

    roots_t expected_roots [$];

    // floor(sqrt(d * 4^FRAC_W)), two bits of d per digit
    function automatic longint unsigned scaled_isqrt(longint unsigned d);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned pair;
        longint unsigned trial;
        root = 0;
        rem  = 0;
        for (int i = 31; i >= -qrs_pkg::FRAC_W; i--) begin
            pair  = (i >= 0) ? ((d >> (2 * i)) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic roots_t solve_quadratic(logic signed [qrs_pkg::COEF_W-1:0] ca,
                                               logic signed [qrs_pkg::COEF_W-1:0] cb,
                                               logic signed [qrs_pkg::COEF_W-1:0] cc);
        longint a;
        longint b;
        longint c;
        longint d;
        longint den;
        longint nb;
        longint s;
        roots_t r;
        a = ca;
        b = cb;
        c = cc;
        d = b * b - 4 * (a * c);
        r.plus  = '0;
        r.minus = '0;
        r.disc  = d[qrs_pkg::DISC_W-1:0];
        if (a == 0) begin
            r.cls = qrs_pkg::CLS_DEGENERATE;
        end else if (d < 0) begin
            r.cls = qrs_pkg::CLS_COMPLEX;
        end else begin
            den = 2 * a;
            nb  = -b * (longint'(1) << qrs_pkg::FRAC_W);
            if (d == 0) begin
                r.cls   = qrs_pkg::CLS_ONE_REAL;
                r.plus  = qrs_pkg::ROOT_W'(nb / den);
                r.minus = r.plus;
            end else begin
                s       = longint'(scaled_isqrt(d));
                r.cls   = qrs_pkg::CLS_TWO_REAL;
                r.plus  = qrs_pkg::ROOT_W'((nb + s) / den);
                r.minus = qrs_pkg::ROOT_W'((nb - s) / den);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign pending_count = expected_roots.size();

    // predict on input transaction, compare on output transaction
    always @(posedge aclk) begin
        roots_t want;
        if (!aresetn) begin
            expected_roots.delete();
            fail_count = 0;
            for (int k = 0; k < 4; k++) class_seen[k] = 0;
        end else begin
            if (s_valid && s_ready)
                expected_roots.push_back(solve_quadratic(s_coef_a, s_coef_b, s_coef_c));
            if (m_valid && m_ready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 0);
                end else begin
                    want = expected_roots.pop_front();
                    class_seen[want.cls]++;
                    if (m_root_class != want.cls)
                        report_mismatch("root_class", m_root_class, want.cls);
                    if (m_root_plus != want.plus)
                        report_mismatch("root_plus", m_root_plus, want.plus);
                    if (m_root_minus != want.minus)
                        report_mismatch("root_minus", m_root_minus, want.minus);
                    if (m_discriminant != want.disc)
                        report_mismatch("discriminant", m_discriminant, want.disc);
                end
            end
        end
    end
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int LATENCY   = 4 + qrs_pkg::SQ_STEPS + qrs_pkg::DIV_STEPS;
    localparam int IDLE_LIMIT = 5000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [qrs_pkg::COEF_W-1:0] s_coef_a;
    logic signed [qrs_pkg::COEF_W-1:0] s_coef_b;
    logic signed [qrs_pkg::COEF_W-1:0] s_coef_c;
    logic m_valid;
    logic m_ready;
    logic [1:0] m_root_class;
    logic signed [qrs_pkg::ROOT_W-1:0] m_root_plus;
    logic signed [qrs_pkg::ROOT_W-1:0] m_root_minus;
    logic signed [qrs_pkg::DISC_W-1:0] m_discriminant;
    int fail_count;
    int pending_count;
    int class_seen [4];
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_off;
    int quiet_cycles;
    int sent;

    quadratic_root_solver dut (.*);

    root_checker checker_inst (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // offer one coefficient set and wait until it is accepted
    task automatic send_coefs(logic [qrs_pkg::COEF_W-1:0] a, logic [qrs_pkg::COEF_W-1:0] b,
                              logic [qrs_pkg::COEF_W-1:0] c);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        @(negedge aclk);
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [qrs_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(signed'($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // random, degenerate, or built from chosen roots so double roots and real roots are common
    task automatic send_random();
        int kind;
        int r1;
        int r2;
        int k;
        kind = $urandom_range(9);
        if (kind < 5) begin
            send_coefs(rand_coef(), rand_coef(), rand_coef());
        end else if (kind < 7) begin
            r1 = $urandom_range(200) - 100;
            k  = $urandom_range(3) + 1;
            if ($urandom_range(1)) k = -k;
            send_coefs(16'(k), 16'(-2 * k * r1), 16'(k * r1 * r1));
        end else if (kind < 9) begin
            r1 = $urandom_range(120) - 60;
            r2 = $urandom_range(120) - 60;
            k  = $urandom_range(4) + 1;
            send_coefs(16'(k), 16'(-k * (r1 + r2)), 16'(k * r1 * r2));
        end else begin
            send_coefs(16'd0, rand_coef(), rand_coef());
        end
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(negedge aclk);
    endtask

    initial begin
        hold_off = 0;
        sent = 0;
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_coef_a = '0;
        s_coef_b = '0;
        s_coef_c = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, each root class
        sender_idle_pct = 25;
        receiver_idle_pct = 75;
        send_coefs(16'd1, 16'hfffd, 16'd2);
        send_coefs(16'd1, 16'hfffe, 16'd1);
        send_coefs(16'd1, 16'd0, 16'd1);
        send_coefs(16'd0, 16'd5, 16'd3);
        send_coefs(16'd0, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h7fff, 16'h8000);
        send_coefs(16'h7fff, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h7fff, 16'h7fff);
        send_coefs(16'h7fff, 16'h0000, 16'h8000);
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'hffff, 16'h0002, 16'hffff);
        send_coefs(16'h0002, 16'h0003, 16'hffff);
        send_coefs(16'hfffe, 16'h0001, 16'h0001);
        send_coefs(16'd1, 16'd0, 16'd0);
        send_coefs(16'd3, 16'd1, 16'd0);
        send_coefs(16'h5555, 16'haaaa, 16'h5555);
        send_coefs(16'haaaa, 16'h5555, 16'haaaa);

        // pause until every expected result has come
        go_idle();
        wait_drained();

        // long receiver hold-off while input keeps coming
        hold_off = 300;
        sender_idle_pct = 0;
        repeat (150) send_random();

        sender_idle_pct = 25;
        receiver_idle_pct = 75;
        for (int n = 0; n < 330; n++) send_random();
        sender_idle_pct = 75;
        receiver_idle_pct = 25;
        for (int n = 0; n < 330; n++) send_random();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        for (int n = 0; n < 330; n++) send_random();
        go_idle();

        wait_drained();
        repeat (LATENCY + 10) @(negedge aclk);
        $display("sent %0d coefficient sets across three stall patterns and a long hold-off",
                 sent);
        $display("classes checked: two real %0d, one real %0d, complex %0d, degenerate %0d",
                 class_seen[0], class_seen[1], class_seen[2], class_seen[3]);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
